>>> src/wfq_virtual_time_finish_tag_defines.svh
// Assertion macros shared by the finish-tag unit.
`ifndef WFQ_VIRTUAL_TIME_FINISH_TAG_DEFINES_SVH
`define WFQ_VIRTUAL_TIME_FINISH_TAG_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define WFQ_ASSERT_IMPLY(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("wfq assertion failed");

// Next-cycle implication, disabled while reset is held.
`define WFQ_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("wfq assertion failed");

`endif

>>> src/wfq_pkg.sv
// ----------------------------------------------------------------------------
// wfq_pkg
// Shared types and constants of the WFQ finish-tag unit.
// ----------------------------------------------------------------------------
package wfq_pkg;

    localparam int TAG_W = 48;
    localparam logic [TAG_W-1:0] TAG_MAX = '1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [1:0] ST_RING_FULL  = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_LK_CHK, OP_DECIDE,
        OP_A_INIT, OP_A_FLOW, OP_A_END, OP_A_ENTRY, OP_A_NEXT,
        OP_X, OP_X_FIN,
        OP_B_INIT, OP_B_FLOW, OP_B_ENTRY, OP_B_NEXT, OP_B_LIM, OP_MUL_FIN,
        OP_FT, OP_FT_FIN, OP_COMMIT,
        OP_P_FLOW, OP_P_ENTRY, OP_P_WB, OP_P_NEXT
    } t_op;

    typedef enum logic {MD_DIV, MD_MUL} t_md_mode;

    typedef struct packed {
        logic match;
        logic f_last;
        logic valid;
        logic drop;
        logic k_end;
        logic dep;
        logic sum_zero;
        logic b_go;
        logic found;
        logic md_done;
        logic cnt_zero;
        logic prune;
    } t_dp_status;

endpackage

>>> src/wfq_muldiv.sv
// ----------------------------------------------------------------------------
// wfq_muldiv
// Bit-serial unit: restoring divide of a 48-bit word, or a saturation-aware
// shift-add multiply.
// ----------------------------------------------------------------------------
module wfq_muldiv
    import wfq_pkg::*;
#(
    parameter int DW = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_md_mode         i_mode,
    input  logic [TAG_W-1:0] i_a,
    input  logic [DW-1:0]    i_b,
    output logic             o_done,
    output logic [TAG_W-1:0] o_res,
    output logic             o_ovf
);

    localparam int CNW = $clog2(TAG_W + 1);

    logic             r_busy, r_done, r_ovf;
    t_md_mode         r_mode;
    logic [CNW-1:0]   r_cnt;
    logic [TAG_W-1:0] r_acc, r_a;
    logic [DW-1:0]    r_rem, r_b;

    logic [DW:0]      rem_sh;
    logic             ge;
    logic [TAG_W+1:0] mtmp;

    assign rem_sh = {r_rem, r_acc[TAG_W-1]};
    assign ge     = rem_sh >= {1'b0, r_b};
    assign mtmp   = {1'b0, r_acc, 1'b0} + (r_b[DW-1] ? {2'b00, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_mode <= i_mode;
                r_a    <= i_a;
                r_b    <= i_b;
                r_rem  <= '0;
                r_ovf  <= 1'b0;
                if (i_mode == MD_DIV) begin
                    r_acc <= i_a;
                    r_cnt <= CNW'(TAG_W);
                end else begin
                    r_acc <= '0;
                    r_cnt <= CNW'(DW);
                end
            end else if (r_busy) begin
                if (r_mode == MD_DIV) begin
                    r_rem <= ge ? DW'(rem_sh - {1'b0, r_b}) : rem_sh[DW-1:0];
                    r_acc <= {r_acc[TAG_W-2:0], ge};
                end else begin
                    // Once the product passes the 48-bit range the overflow flag stays set.
                    if (mtmp > {2'b00, TAG_MAX}) r_ovf <= 1'b1;
                    r_acc <= mtmp[TAG_W-1:0];
                    r_b   <= {r_b[DW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CNW'(1);
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;
    assign o_ovf  = r_ovf;

endmodule

>>> src/wfq_ctrl.sv
// ----------------------------------------------------------------------------
// wfq_ctrl
// Sequencer: lookup, GPS advance passes, tag computation, commit and prune.
// ----------------------------------------------------------------------------
module wfq_ctrl
    import wfq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_op        o_op,
    output logic       o_busy,
    output logic       o_done
);

    typedef enum logic [4:0] {
        S_IDLE, S_LK_RD, S_LK_CHK, S_DECIDE,
        S_A_INIT, S_A_FRD, S_A_FCHK, S_A_RRD, S_A_RCHK, S_A_NEXT,
        S_X, S_X_DIV,
        S_B_INIT, S_B_FRD, S_B_FCHK, S_B_RRD, S_B_RCHK, S_B_NEXT, S_B_END,
        S_MUL, S_FT, S_FT_DIV, S_COMMIT,
        S_P_FRD, S_P_FCHK, S_P_RRD, S_P_RCHK, S_P_WB, S_P_NEXT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, r_done, n_done;
    t_op    op;

    always_comb begin
        n_state = r_state;
        op      = OP_NONE;
        n_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    op      = OP_LOAD;
                    n_state = S_LK_RD;
                end
            end
            S_LK_RD:  n_state = S_LK_CHK;
            S_LK_CHK: begin
                op      = OP_LK_CHK;
                n_state = (i_status.match || i_status.f_last) ? S_DECIDE : S_LK_RD;
            end
            S_DECIDE: begin
                op = OP_DECIDE;
                if (i_status.drop) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_state = S_A_INIT;
                end
            end
            S_A_INIT: begin
                op      = OP_A_INIT;
                n_state = S_A_FRD;
            end
            S_A_FRD:  n_state = S_A_FCHK;
            S_A_FCHK: begin
                op      = OP_A_FLOW;
                n_state = i_status.valid ? S_A_RRD : S_A_NEXT;
            end
            S_A_RRD: begin
                if (i_status.k_end) begin
                    op      = OP_A_END;
                    n_state = S_A_NEXT;
                end else begin
                    n_state = S_A_RCHK;
                end
            end
            S_A_RCHK: begin
                op      = OP_A_ENTRY;
                n_state = i_status.dep ? S_A_RRD : S_A_NEXT;
            end
            S_A_NEXT: begin
                op      = OP_A_NEXT;
                n_state = i_status.f_last ? S_X : S_A_FRD;
            end
            S_X: begin
                op      = OP_X;
                n_state = i_status.sum_zero ? S_FT : S_X_DIV;
            end
            S_X_DIV: begin
                if (i_status.md_done) begin
                    op      = OP_X_FIN;
                    n_state = S_B_INIT;
                end
            end
            S_B_INIT: begin
                op      = OP_B_INIT;
                n_state = S_B_FRD;
            end
            S_B_FRD:  n_state = S_B_FCHK;
            S_B_FCHK: begin
                op      = OP_B_FLOW;
                n_state = i_status.b_go ? S_B_RRD : S_B_NEXT;
            end
            S_B_RRD:  n_state = S_B_RCHK;
            S_B_RCHK: begin
                op      = OP_B_ENTRY;
                n_state = S_B_NEXT;
            end
            S_B_NEXT: begin
                op      = OP_B_NEXT;
                n_state = i_status.f_last ? S_B_END : S_B_FRD;
            end
            S_B_END: begin
                if (i_status.found) begin
                    op      = OP_B_LIM;
                    n_state = S_MUL;
                end else begin
                    n_state = S_FT;
                end
            end
            S_MUL: begin
                if (i_status.md_done) begin
                    op      = OP_MUL_FIN;
                    n_state = S_A_INIT;
                end
            end
            S_FT: begin
                op      = OP_FT;
                n_state = S_FT_DIV;
            end
            S_FT_DIV: begin
                if (i_status.md_done) begin
                    op      = OP_FT_FIN;
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                op      = OP_COMMIT;
                n_state = S_P_FRD;
            end
            S_P_FRD:  n_state = S_P_FCHK;
            S_P_FCHK: begin
                op      = OP_P_FLOW;
                n_state = i_status.valid ? S_P_RRD : S_P_NEXT;
            end
            S_P_RRD:  n_state = i_status.cnt_zero ? S_P_WB : S_P_RCHK;
            S_P_RCHK: begin
                op      = OP_P_ENTRY;
                n_state = i_status.prune ? S_P_RRD : S_P_WB;
            end
            S_P_WB: begin
                op      = OP_P_WB;
                n_state = S_P_NEXT;
            end
            S_P_NEXT: begin
                op = OP_P_NEXT;
                if (i_status.f_last) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_state = S_P_FRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_state != S_IDLE;
            r_done  <= n_done;
        end
    end

    assign o_op   = op;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

>>> src/wfq_dp.sv
// ----------------------------------------------------------------------------
// wfq_dp
// Datapath: flow table, per-flow tag rings, GPS clock registers and the
// shared multiply/divide unit.
// ----------------------------------------------------------------------------
module wfq_dp
    import wfq_pkg::*;
#(
    parameter int MAX_FLOWS  = 16,
    parameter int RING_DEPTH = 16,
    parameter int FRAC_BITS  = 16,
    localparam int FW = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_op              i_op,
    input  logic [31:0]      i_arrival_time,
    input  logic [31:0]      i_src_address,
    input  logic [15:0]      i_src_port,
    input  logic [31:0]      i_dst_address,
    input  logic [15:0]      i_dst_port,
    input  logic [15:0]      i_packet_length,
    input  logic [15:0]      i_flow_weight_in,
    output t_dp_status       o_status,
    output logic [TAG_W-1:0] o_finish_tag,
    output logic [TAG_W-1:0] o_virtual_time,
    output logic [FW-1:0]    o_flow_slot,
    output logic             o_new_flow,
    output logic [15:0]      o_used_weight,
    output logic [1:0]       o_status_code
);

    localparam int HW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW   = $clog2(RING_DEPTH + 1);
    localparam int CW1  = CW + 1;
    localparam int SW   = 16 + $clog2(MAX_FLOWS);
    localparam int RSZ  = MAX_FLOWS * RING_DEPTH;
    localparam int RAW  = (RSZ > 1) ? $clog2(RSZ) : 1;
    localparam int RAXW = $clog2(RSZ + 1) + 1;
    localparam int TSW  = 32 + FRAC_BITS;

    typedef struct packed {
        logic [TAG_W-1:0] k0;
        logic [TAG_W-1:0] k1;
        logic [15:0]      weight;
        logic [TAG_W-1:0] last;
    } t_frec;

    typedef struct packed {
        logic [HW-1:0] head;
        logic [CW-1:0] count;
    } t_ptr;

    typedef struct packed {
        logic [TAG_W-1:0] start;
        logic [15:0]      weight;
        logic [TAG_W-1:0] finish;
    } t_rent;

    t_frec fk_mem   [MAX_FLOWS];
    t_ptr  ptr_mem  [MAX_FLOWS];
    logic [CW-1:0] snap_mem [MAX_FLOWS];
    t_rent ring_mem [RSZ];

    t_frec         r_fk_rd;
    t_ptr          r_ptr_rd;
    logic [CW-1:0] r_snap_rd;
    t_rent         r_rg_rd;

    logic [MAX_FLOWS-1:0] r_valid;
    logic [TAG_W-1:0] r_vt, r_rt, r_t, r_old_v, r_old_t, r_lim, r_base, r_tag;
    logic [TAG_W-1:0] r_k0, r_k1;
    logic [15:0]      r_len, r_win, r_w;
    logic [FW-1:0]    r_f, r_slot, r_free_slot;
    logic             r_hit, r_free_found, r_new, r_found, r_startok;
    logic [1:0]       r_status;
    logic [15:0]      r_rec_weight;
    logic [TAG_W-1:0] r_rec_last;
    logic [HW-1:0]    r_rec_head, r_cur_head;
    logic [CW-1:0]    r_rec_count, r_cur_count, r_k, r_d;
    logic [SW-1:0]    r_sum;

    logic             md_start, md_done, md_ovf;
    t_md_mode         md_mode;
    logic [TAG_W-1:0] md_a, md_res, x_val, diff_val;
    logic [SW-1:0]    md_b;
    logic [TSW-1:0]   tsh;
    logic             match, f_last, startok_n, dep;
    logic [RAW-1:0]   rd_addr, wr_addr;
    logic [CW1-1:0]   head_inc;

    function automatic logic [TAG_W-1:0] sat_add(input logic [TAG_W-1:0] a,
                                                 input logic [TAG_W-1:0] b);
        logic [TAG_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TAG_W] ? TAG_MAX : s[TAG_W-1:0];
    endfunction

    function automatic logic [RAW-1:0] ring_addr(input logic [FW-1:0] f,
                                                 input logic [HW-1:0] h,
                                                 input logic [CW-1:0] k);
        logic [CW1-1:0]  s;
        logic [RAXW-1:0] a;
        s = CW1'(h) + CW1'(k);
        if (s >= CW1'(RING_DEPTH)) s = s - CW1'(RING_DEPTH);
        a = RAXW'(f) * RAXW'(RING_DEPTH) + RAXW'(s);
        return a[RAW-1:0];
    endfunction

    assign tsh       = TSW'(i_arrival_time) << FRAC_BITS;
    assign match     = r_valid[r_f] && (r_fk_rd.k0 == r_k0) && (r_fk_rd.k1 == r_k1);
    assign f_last    = r_f == FW'(MAX_FLOWS - 1);
    assign startok_n = r_startok && (r_rg_rd.start <= r_old_v);
    assign dep       = r_rg_rd.finish <= r_old_v;
    assign x_val     = (r_t > r_old_t) ? r_t - r_old_t : '0;
    assign diff_val  = (r_lim > r_old_v) ? r_lim - r_old_v : '0;
    assign rd_addr   = ring_addr(r_f, r_cur_head, r_k);
    assign wr_addr   = ring_addr(r_slot, r_rec_head, r_rec_count);
    assign head_inc  = CW1'(r_cur_head) + CW1'(1);

    assign md_start = (i_op == OP_X && r_sum != '0) || i_op == OP_B_LIM || i_op == OP_FT;
    assign md_mode  = (i_op == OP_B_LIM) ? MD_MUL : MD_DIV;
    always_comb begin
        case (i_op)
            OP_X: begin
                md_a = x_val;
                md_b = r_sum;
            end
            OP_B_LIM: begin
                md_a = diff_val;
                md_b = r_sum;
            end
            default: begin
                md_a = TAG_W'(r_len) << FRAC_BITS;
                md_b = SW'(r_w);
            end
        endcase
    end

    wfq_muldiv #(.DW(SW)) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_mode  (md_mode),
        .i_a     (md_a),
        .i_b     (md_b),
        .o_done  (md_done),
        .o_res   (md_res),
        .o_ovf   (md_ovf)
    );

    // Memories: one registered read per cycle, one write port each.
    always_ff @(posedge i_clk) begin
        r_fk_rd   <= fk_mem[r_f];
        r_ptr_rd  <= ptr_mem[r_f];
        r_snap_rd <= snap_mem[r_f];
        r_rg_rd   <= ring_mem[rd_addr];
        if (i_op == OP_COMMIT) begin
            fk_mem[r_slot]    <= '{k0: r_k0, k1: r_k1, weight: r_w, last: r_tag};
            ptr_mem[r_slot]   <= '{head: r_rec_head, count: r_rec_count + CW'(1)};
            ring_mem[wr_addr] <= '{start: r_vt, weight: r_w, finish: r_tag};
        end else if (i_op == OP_P_WB) begin
            ptr_mem[r_f] <= '{head: r_cur_head, count: r_cur_count};
        end
        if (i_op == OP_A_END || (i_op == OP_A_ENTRY && !dep)) begin
            snap_mem[r_f] <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_vt    <= '0;
            r_rt    <= '0;
        end else begin
            case (i_op)
                OP_LOAD: begin
                    r_t          <= (tsh > TSW'(TAG_MAX)) ? TAG_MAX : TAG_W'(tsh);
                    r_k0         <= {i_src_address, i_src_port};
                    r_k1         <= {i_dst_address, i_dst_port};
                    r_len        <= i_packet_length;
                    r_win        <= i_flow_weight_in;
                    r_f          <= '0;
                    r_hit        <= 1'b0;
                    r_free_found <= 1'b0;
                    r_tag        <= '0;
                end
                OP_LK_CHK: begin
                    if (match) begin
                        r_hit        <= 1'b1;
                        r_slot       <= r_f;
                        r_rec_weight <= r_fk_rd.weight;
                        r_rec_last   <= r_fk_rd.last;
                        r_rec_head   <= r_ptr_rd.head;
                        r_rec_count  <= r_ptr_rd.count;
                    end else begin
                        if (!r_valid[r_f] && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_slot  <= r_f;
                        end
                        if (!f_last) r_f <= r_f + FW'(1);
                    end
                end
                OP_DECIDE: begin
                    r_new <= 1'b0;
                    if (r_hit) begin
                        r_w      <= (r_win != '0) ? r_win : r_rec_weight;
                        r_status <= (r_rec_count >= CW'(RING_DEPTH)) ? ST_RING_FULL : ST_OK;
                    end else begin
                        r_w <= (r_win != '0) ? r_win : 16'd1;
                        if (r_free_found) begin
                            r_slot      <= r_free_slot;
                            r_new       <= 1'b1;
                            r_status    <= ST_OK;
                            r_rec_head  <= '0;
                            r_rec_count <= '0;
                        end else begin
                            r_slot   <= '0;
                            r_status <= ST_TABLE_FULL;
                        end
                    end
                end
                OP_A_INIT: begin
                    r_f     <= '0;
                    r_sum   <= '0;
                    r_old_v <= r_vt;
                    r_old_t <= r_rt;
                end
                OP_A_FLOW: begin
                    r_cur_head  <= r_ptr_rd.head;
                    r_cur_count <= r_ptr_rd.count;
                    r_k         <= '0;
                    r_d         <= '0;
                    r_startok   <= 1'b1;
                end
                OP_A_ENTRY: begin
                    if (dep) begin
                        r_d       <= r_d + CW'(1);
                        r_k       <= r_k + CW'(1);
                        r_startok <= startok_n;
                    end else if (startok_n) begin
                        // Head-of-line packet of this flow is busy in GPS.
                        r_sum <= r_sum + SW'(r_rg_rd.weight);
                    end
                end
                OP_A_NEXT, OP_B_NEXT, OP_P_NEXT: begin
                    if (!f_last) r_f <= r_f + FW'(1);
                end
                OP_X: begin
                    if (r_t > r_old_t) r_rt <= r_t;
                end
                OP_X_FIN: r_vt <= sat_add(r_old_v, md_res);
                OP_B_INIT: begin
                    r_f     <= '0;
                    r_found <= 1'b0;
                end
                OP_B_FLOW: begin
                    r_cur_head <= r_ptr_rd.head;
                    r_k        <= r_snap_rd;
                end
                OP_B_ENTRY: begin
                    if (r_rg_rd.finish <= r_vt && (!r_found || r_rg_rd.finish < r_lim)) begin
                        r_lim   <= r_rg_rd.finish;
                        r_found <= 1'b1;
                    end
                end
                OP_B_LIM: r_vt <= r_lim;
                OP_MUL_FIN: r_rt <= md_ovf ? r_t : sat_add(r_old_t, md_res);
                OP_FT: r_base <= (r_hit && r_rec_last > r_vt) ? r_rec_last : r_vt;
                OP_FT_FIN: r_tag <= sat_add(r_base, md_res);
                OP_COMMIT: begin
                    r_valid[r_slot] <= 1'b1;
                    r_f             <= '0;
                end
                OP_P_FLOW: begin
                    r_cur_head  <= r_ptr_rd.head;
                    r_cur_count <= r_ptr_rd.count;
                    r_k         <= '0;
                end
                OP_P_ENTRY: begin
                    if (r_rg_rd.finish < r_vt) begin
                        r_cur_head  <= (head_inc == CW1'(RING_DEPTH)) ? '0 : HW'(head_inc);
                        r_cur_count <= r_cur_count - CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_status          = '0;
        o_status.match    = match;
        o_status.f_last   = f_last;
        o_status.valid    = r_valid[r_f];
        o_status.drop     = r_hit ? (r_rec_count >= CW'(RING_DEPTH)) : !r_free_found;
        o_status.k_end    = r_k == r_cur_count;
        o_status.dep      = dep;
        o_status.sum_zero = r_sum == '0;
        o_status.b_go     = r_valid[r_f] && (r_snap_rd < r_ptr_rd.count);
        o_status.found    = r_found;
        o_status.md_done  = md_done;
        o_status.cnt_zero = r_cur_count == '0;
        o_status.prune    = r_rg_rd.finish < r_vt;
    end

    assign o_finish_tag   = r_tag;
    assign o_virtual_time = r_vt;
    assign o_flow_slot    = r_slot;
    assign o_new_flow     = r_new;
    assign o_used_weight  = r_w;
    assign o_status_code  = r_status;

endmodule

>>> src/wfq_virtual_time_finish_tag.sv
// ----------------------------------------------------------------------------
// wfq_virtual_time_finish_tag
// WFQ finish-tag unit with GPS virtual-time tracking.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Word
// arrival   in         start & !busy             time, flow 4-tuple, length, weight
// result    out        o_valid, one cycle        finish tag, vtime, slot, flags
//
// One arrival at a time; busy stays high from acceptance until the result strobe.
// Lookup scans the flow slots until a match or the last slot. A GPS pass walks every slot,
// examining the tags of each active flow, then, unless no flow is busy, a divide and a
// second walk of the slots to find departures; a departure adds a multiply and another
// pass. The tag is a divide; then commit, and a prune walk of every slot drops old tags.
// Synchronous reset, no clearing pass; results never stall.
module wfq_virtual_time_finish_tag
    import wfq_pkg::*;
#(
    parameter int MAX_FLOWS  = 16,
    parameter int RING_DEPTH = 16,
    parameter int FRAC_BITS  = 16,
    localparam int FW = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [31:0]      i_arrival_time,
    input  logic [31:0]      i_src_address,
    input  logic [15:0]      i_src_port,
    input  logic [31:0]      i_dst_address,
    input  logic [15:0]      i_dst_port,
    input  logic [15:0]      i_packet_length,
    input  logic [15:0]      i_flow_weight_in,
    output logic             o_valid,
    output logic [TAG_W-1:0] o_finish_tag,
    output logic [TAG_W-1:0] o_virtual_time,
    output logic [FW-1:0]    o_flow_slot,
    output logic             o_new_flow,
    output logic [15:0]      o_used_weight,
    output logic [1:0]       o_status
);

`include "wfq_virtual_time_finish_tag_defines.svh"

    t_op        op;
    t_dp_status dp_status;

    wfq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_op     (op),
        .o_busy   (busy),
        .o_done   (o_valid)
    );

    wfq_dp #(
        .MAX_FLOWS  (MAX_FLOWS),
        .RING_DEPTH (RING_DEPTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .i_arrival_time   (i_arrival_time),
        .i_src_address    (i_src_address),
        .i_src_port       (i_src_port),
        .i_dst_address    (i_dst_address),
        .i_dst_port       (i_dst_port),
        .i_packet_length  (i_packet_length),
        .i_flow_weight_in (i_flow_weight_in),
        .o_status         (dp_status),
        .o_finish_tag     (o_finish_tag),
        .o_virtual_time   (o_virtual_time),
        .o_flow_slot      (o_flow_slot),
        .o_new_flow       (o_new_flow),
        .o_used_weight    (o_used_weight),
        .o_status_code    (o_status)
    );

    `WFQ_ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, o_valid, !busy)
    `WFQ_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `WFQ_ASSERT_IMPLY(a_drop_clean, i_clk, i_rst_n, o_valid && (o_status != ST_OK), !o_new_flow && (o_finish_tag == '0))
    `WFQ_ASSERT_IMPLY(a_weight_set, i_clk, i_rst_n, o_valid, o_used_weight != '0)

endmodule

>>> tb/sv/wfq_virtual_time_finish_tag_tb.sv
// ----------------------------------------------------------------------------
// wfq_virtual_time_finish_tag_tb
// Self-checking bench for the WFQ finish-tag unit: a directed table of packet
// arrivals followed by random bursts, each result compared with a GPS model.
// ----------------------------------------------------------------------------
module wfq_virtual_time_finish_tag_tb
    import wfq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFLOW = 16;
    localparam int NRING = 16;
    localparam int FRAC = 16;
    localparam int NKEY = 24;
    localparam int NRANDOM = 1500;
    localparam longint unsigned LIMIT = 64'd60_000_000;
    localparam longint unsigned M48 = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [TAG_W-1:0] tag;
        logic [TAG_W-1:0] vtime;
        logic [3:0]       slot;
        logic             is_new;
        logic [15:0]      weight;
        logic [1:0]       status;
    } t_result;

    typedef struct {
        logic [31:0] arrival;
        int          key_idx;
        logic [15:0] length;
        logic [15:0] weight;
        int          repeats;
        bit          step_key;
        bit          has_exp;
        t_result     exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_arrival_time;
    logic [31:0] i_src_address;
    logic [15:0] i_src_port;
    logic [31:0] i_dst_address;
    logic [15:0] i_dst_port;
    logic [15:0] i_packet_length;
    logic [15:0] i_flow_weight_in;
    logic             o_valid;
    logic [TAG_W-1:0] o_finish_tag;
    logic [TAG_W-1:0] o_virtual_time;
    logic [3:0]       o_flow_slot;
    logic             o_new_flow;
    logic [15:0]      o_used_weight;
    logic [1:0]       o_status;

    wfq_virtual_time_finish_tag uut (.*);

    // Model state of the flow table, the tag rings and GPS time.
    bit               fl_valid [NFLOW];
    logic [47:0]      fl_k0 [NFLOW];
    logic [47:0]      fl_k1 [NFLOW];
    longint unsigned  fl_weight [NFLOW];
    longint unsigned  fl_last [NFLOW];
    longint unsigned  rg_start [NFLOW*NRING];
    longint unsigned  rg_weight [NFLOW*NRING];
    longint unsigned  rg_finish [NFLOW*NRING];
    int               rg_head [NFLOW];
    int               rg_count [NFLOW];
    int               snap_dep [NFLOW];
    longint unsigned  gps_vt;
    longint unsigned  gps_rt;

    logic [31:0] key_src_addr [NKEY];
    logic [15:0] key_src_port [NKEY];
    logic [31:0] key_dst_addr [NKEY];
    logic [15:0] key_dst_port [NKEY];

    t_result pending_results [$];
    t_row    rows [$];
    int      errors = 0;
    longint unsigned cycles = 0;

    function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = (a & M48) + (b & M48);
        return (s > M48) ? M48 : s;
    endfunction

    function automatic int slot_pos(int f, int k);
        return f * NRING + (rg_head[f] + k) % NRING;
    endfunction

    function automatic int tags_done(int f, longint unsigned v);
        int d;
        d = 0;
        for (int k = 0; k < rg_count[f]; k++) begin
            if (rg_finish[slot_pos(f, k)] <= v) d++;
            else break;
        end
        return d;
    endfunction

    // Weight of the packet now in GPS service on this flow, zero if none.
    function automatic longint unsigned head_weight(int f, int d, longint unsigned v);
        int a;
        int p;
        a = 0;
        for (int k = 0; k < rg_count[f]; k++) begin
            p = slot_pos(f, k);
            if (rg_start[p] <= v) begin
                a++;
                if (a == d + 1) return rg_weight[p];
            end else begin
                break;
            end
        end
        return 0;
    endfunction

    task automatic advance_gps(longint unsigned t);
        longint unsigned old_v, old_t, sum, x, lim, diff, nt;
        int old_d, new_d, d;
        bit found;
        for (int iter = 0; iter <= NFLOW * NRING + 1; iter++) begin
            old_v = gps_vt;
            old_t = gps_rt;
            sum = 0;
            lim = 0;
            old_d = 0;
            new_d = 0;
            found = 0;
            for (int f = 0; f < NFLOW; f++) begin
                if (fl_valid[f]) begin
                    d = tags_done(f, old_v);
                    snap_dep[f] = d;
                    old_d += d;
                    sum += head_weight(f, d, old_v);
                end
            end
            x = (t > old_t) ? t - old_t : 0;
            if (t > old_t) gps_rt = t;
            if (sum == 0) return;
            gps_vt = add_sat(old_v, x / sum);
            for (int f = 0; f < NFLOW; f++) begin
                if (fl_valid[f]) begin
                    d = tags_done(f, gps_vt);
                    new_d += d;
                    if (d > snap_dep[f]) begin
                        if (!found || rg_finish[slot_pos(f, snap_dep[f])] < lim)
                            lim = rg_finish[slot_pos(f, snap_dep[f])];
                        found = 1;
                    end
                end
            end
            if (new_d > old_d && found) begin
                // Stop at the earliest departure and move real time to match.
                diff = (lim > old_v) ? lim - old_v : 0;
                gps_vt = lim;
                if (diff > M48 / sum) nt = t;
                else nt = old_t + diff * sum;
                gps_rt = (nt > M48) ? M48 : nt;
            end else begin
                return;
            end
        end
    endtask

    task automatic predict_finish_tag(output t_result r);
        longint unsigned t, len, w, tag, base;
        logic [47:0] k0, k1;
        int slot, p;
        bit hit, is_new;
        logic [1:0] st;
        t = longint'(i_arrival_time) << FRAC;
        k0 = {i_src_address, i_src_port};
        k1 = {i_dst_address, i_dst_port};
        len = i_packet_length;
        hit = 0;
        is_new = 0;
        slot = 0;
        tag = 0;
        st = ST_OK;
        for (int f = 0; f < NFLOW; f++) begin
            if (fl_valid[f] && fl_k0[f] == k0 && fl_k1[f] == k1) begin
                hit = 1;
                slot = f;
                break;
            end
        end
        if (hit) begin
            w = (i_flow_weight_in != 0) ? i_flow_weight_in : fl_weight[slot];
            if (rg_count[slot] >= NRING) st = ST_RING_FULL;
        end else begin
            w = (i_flow_weight_in != 0) ? i_flow_weight_in : 1;
            st = ST_TABLE_FULL;
            for (int f = 0; f < NFLOW; f++) begin
                if (!fl_valid[f]) begin
                    slot = f;
                    st = ST_OK;
                    is_new = 1;
                    break;
                end
            end
        end
        if (st == ST_OK) begin
            fl_weight[slot] = w;
            advance_gps(t);
            base = gps_vt;
            if (hit && fl_last[slot] > base) base = fl_last[slot];
            tag = add_sat(base, (len << FRAC) / ((w != 0) ? w : 1));
            p = slot_pos(slot, rg_count[slot]);
            rg_start[p] = gps_vt;
            rg_weight[p] = w;
            rg_finish[p] = tag;
            rg_count[slot]++;
            fl_last[slot] = tag;
            if (is_new) begin
                fl_valid[slot] = 1;
                fl_k0[slot] = k0;
                fl_k1[slot] = k1;
            end
            for (int f = 0; f < NFLOW; f++) begin
                if (fl_valid[f]) begin
                    while (rg_count[f] > 0 && rg_finish[slot_pos(f, 0)] < gps_vt) begin
                        rg_head[f] = (rg_head[f] + 1) % NRING;
                        rg_count[f]--;
                    end
                end
            end
        end else begin
            is_new = 0;
        end
        r.tag = tag[47:0];
        r.vtime = gps_vt[47:0];
        r.slot = slot[3:0];
        r.is_new = is_new;
        r.weight = w[15:0];
        r.status = st;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(logic [31:0] arr, int key, logic [15:0] len,
                             logic [15:0] wt, bit has_exp, t_result exp);
        t_result r;
        start <= 1'b1;
        i_arrival_time <= arr;
        i_src_address <= key_src_addr[key];
        i_src_port <= key_src_port[key];
        i_dst_address <= key_dst_addr[key];
        i_dst_port <= key_dst_port[key];
        i_packet_length <= len;
        i_flow_weight_in <= wt;
        do @(posedge i_clk); while (busy);
        predict_finish_tag(r);
        pending_results.insert(pending_results.size(), has_exp ? exp : r);
        @(negedge i_clk);
    endtask

    task automatic add_row(logic [31:0] arr, int key, logic [15:0] len, logic [15:0] wt,
                           int rep, bit step_key);
        t_row row;
        row.arrival = arr;
        row.key_idx = key;
        row.length = len;
        row.weight = wt;
        row.repeats = rep;
        row.step_key = step_key;
        row.has_exp = 0;
        row.exp = '{default: '0};
        rows.insert(rows.size(), row);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = pending_results[0];
                pending_results.delete(0);
                if (o_finish_tag !== e.tag) begin
                    $error("finish_tag: expected %h, got %h", e.tag, o_finish_tag);
                    errors++;
                end
                if (o_virtual_time !== e.vtime) begin
                    $error("virtual_time: expected %h, got %h", e.vtime, o_virtual_time);
                    errors++;
                end
                if (o_flow_slot !== e.slot) begin
                    $error("flow_slot: expected %0d, got %0d", e.slot, o_flow_slot);
                    errors++;
                end
                if (o_new_flow !== e.is_new) begin
                    $error("new_flow: expected %0d, got %0d", e.is_new, o_new_flow);
                    errors++;
                end
                if (o_used_weight !== e.weight) begin
                    $error("used_weight: expected %0d, got %0d", e.weight, o_used_weight);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_row row;
        t_result none;
        logic [31:0] now;
        logic [31:0] arr;
        logic [15:0] len, wt;
        int key, burst, sent, pick, gap;

        none = '{default: '0};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_arrival_time = '0;
        i_src_address = '0;
        i_src_port = '0;
        i_dst_address = '0;
        i_dst_port = '0;
        i_packet_length = '0;
        i_flow_weight_in = '0;
        for (int i = 0; i < NKEY; i++) begin
            key_src_addr[i] = $urandom;
            key_src_port[i] = $urandom;
            key_dst_addr[i] = $urandom;
            key_dst_port[i] = $urandom;
        end
        for (int f = 0; f < NFLOW; f++) begin
            fl_valid[f] = 0;
            rg_head[f] = 0;
            rg_count[f] = 0;
            snap_dep[f] = 0;
        end
        gps_vt = 0;
        gps_rt = 0;

        // First arrival after reset: new flow in slot 0, zero length, default weight.
        add_row(32'd0, 0, 16'd0, 16'd0, 1, 0);
        rows[0].has_exp = 1;
        rows[0].exp = '{tag: '0, vtime: '0, slot: 4'd0, is_new: 1'b1,
                        weight: 16'd1, status: ST_OK};
        add_row(32'd0, 0, 16'hFFFF, 16'hFFFF, 1, 0);
        add_row(32'd10, 1, 16'd100, 16'd0, 1, 0);
        add_row(32'd5, 1, 16'd10, 16'd3, 1, 0);       // arrival time goes backward
        add_row(32'd20, 2, 16'hFFFF, 16'd1, 17, 0);   // last one finds the ring full
        add_row(32'd30, 3, 16'd1, 16'd2, 17, 1);      // fills the table, then overflows

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (rows[r]) begin
            row = rows[r];
            for (int k = 0; k < row.repeats; k++)
                send_word(row.arrival, row.step_key ? row.key_idx + k : row.key_idx,
                          row.length, row.weight, row.has_exp, row.exp);
        end

        // Random bursts: mostly known flows at slowly rising times, some noise.
        now = 32'd40;
        sent = 0;
        while (sent < NRANDOM) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < NRANDOM; b++) begin
                pick = $urandom_range(0, 99);
                key = (pick < 90) ? $urandom_range(0, NFLOW - 1) : $urandom_range(0, NKEY - 1);
                now = now + ((pick < 70) ? $urandom_range(0, 40) : $urandom_range(0, 2000));
                arr = (pick == 99) ? now - $urandom_range(1, 30) : now;
                if (sent >= NRANDOM - 40) arr = $urandom;
                if (sent == NRANDOM - 1) arr = 32'hFFFF_FFFF;
                len = (pick < 85) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
                pick = $urandom_range(0, 9);
                wt = (pick < 5) ? 16'd0 : (pick < 9) ? 16'($urandom_range(1, 8)) : 16'($urandom);
                send_word(arr, key, len, wt, 0, none);
                sent++;
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
